// ===== design/aes_pkg.sv =====
// Shared types, constants and round functions for the AES ECB block.
package aes_pkg;

    localparam int unsigned NUM_RK   = 15;
    localparam int unsigned RK_AW    = $clog2(NUM_RK);
    localparam int unsigned BLK_W    = 128;
    localparam int unsigned KEY_W    = 256;
    localparam int unsigned CFG_IW   = 3;
    localparam int unsigned CFG_DW   = 64;

    typedef logic [RK_AW-1:0] t_rk_addr;
    typedef logic [BLK_W-1:0] t_blk;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_KEY_SIZE  = 3'd0,
        CFG_DIRECTION = 3'd1,
        CFG_KEY_W0    = 3'd2,
        CFG_KEY_W1    = 3'd3,
        CFG_KEY_W2    = 3'd4,
        CFG_KEY_W3    = 3'd5
    } t_cfg_idx;

    // Key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [7:0] AES_POLY = 8'h1B;

    // Round key write port from the key expander
    typedef struct packed {
        logic     en;
        t_rk_addr addr;
        t_blk     data;
    } t_rk_wr;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] ISBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    // Rounds for a key size; codes 2 and 3 both act as 256-bit
    function automatic logic [3:0] nr_of(input logic [1:0] ks);
        logic [3:0] nr;
        case (ks)
            KS_128:  nr = 4'd10;
            KS_192:  nr = 4'd12;
            default: nr = 4'd14;
        endcase
        return nr;
    endfunction

    // Key length in 32-bit words
    function automatic logic [3:0] nk_of(input logic [1:0] ks);
        return nr_of(ks) - 4'd6;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ AES_POLY) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] r;
        logic [7:0] p;
        r = '0;
        p = a;
        for (int k = 0; k < 4; k++) begin
            if (m[k]) r = r ^ p;
            p = xt(p);
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
        logic [3:0]      m [4];
        logic [3:0][7:0] ab;
        logic [3:0][7:0] b;
        if (inv) begin
            m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
        end else begin
            m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
        end
        for (int r = 0; r < 4; r++) ab[r] = a[31-8*r -: 8];
        for (int r = 0; r < 4; r++) begin
            b[r] = '0;
            for (int k = 0; k < 4; k++) b[r] = b[r] ^ gmul(ab[k], m[(k - r) & 3]);
        end
        return {b[0], b[1], b[2], b[3]};
    endfunction

    // Forward round without the key addition
    function automatic t_blk enc_round(input t_blk s, input logic last);
        t_blk t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
        if (!last)
            for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_col(t[127-32*c -: 32], 1'b0);
        return t;
    endfunction

    // Inverse round: inverse shift/sub, key, then inverse mix except on the last round
    function automatic t_blk dec_round(input t_blk s, input t_blk key, input logic last);
        t_blk t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r+4*((c+r)&3)) -: 8] = ISBOX[s[127-8*(r+4*c) -: 8]];
        t = t ^ key;
        if (!last)
            for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_col(t[127-32*c -: 32], 1'b1);
        return t;
    endfunction

endpackage

// ===== design/aes_ifs.sv =====
// Valid/ready channel interfaces for blocks, results and configuration.
interface aes_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, block_high, block_low, input ready);
    modport sink   (input valid, block_high, block_low, output ready);
endinterface

interface aes_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/aes_kexp.sv =====
// Key expander: produces one schedule word per cycle while busy, writes one round key row per four words.
module aes_kexp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_key_size,
    input  logic [255:0]           i_key,
    output aes_pkg::t_rk_wr        o_wr,
    output logic                   o_done
);
    import aes_pkg::*;

    logic        r_busy;
    logic [5:0]  r_idx;
    logic [2:0]  r_kpos;
    logic [7:0]  r_rc;
    logic [31:0] r_win [8];
    logic [95:0] r_row;

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic        key_phase;
    logic        rot_pos;
    logic [31:0] t_word;
    logic [31:0] old_word;
    logic [31:0] n_word;

    assign nk        = nk_of(i_key_size);
    assign last_idx  = 6'({nr_of(i_key_size), 2'b00} + 6'd3);
    assign key_phase = ({2'b00, r_idx} < {2'b00, nk, 2'b00} >> 2);
    assign rot_pos   = (r_kpos == 3'd0);

    // Next schedule word: key word first, then the recurrence
    always_comb begin
        case (nk)
            4'd4:    old_word = r_win[4];
            4'd6:    old_word = r_win[2];
            default: old_word = r_win[0];
        endcase
        if (rot_pos)
            t_word = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rc, 24'h0};
        else if (nk == 4'd8 && r_kpos == 3'd4)
            t_word = sub_word(r_win[7]);
        else
            t_word = r_win[7];
        if (key_phase)
            n_word = i_key[255 - 32*int'(r_idx[2:0]) -: 32];
        else
            n_word = old_word ^ t_word;
    end

    assign o_wr.en   = r_busy && (r_idx[1:0] == 2'd3);
    assign o_wr.addr = r_idx[5:2];
    assign o_wr.data = {r_row, n_word};
    assign o_done    = r_busy && (r_idx == last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Word counters, round constant and window
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= '0;
            r_kpos <= '0;
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_idx  <= r_idx + 6'd1;
            r_kpos <= ({1'b0, r_kpos} == nk - 4'd1) ? 3'd0 : r_kpos + 3'd1;
            if (!key_phase && rot_pos) r_rc <= xt(r_rc);
            for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
            r_win[7] <= n_word;
            r_row    <= {r_row[63:0], n_word};
        end
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_busy) else $error("expander still busy after done");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> o_wr.addr <= nr_of(i_key_size)) else $error("row beyond schedule");
    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> {1'b0, r_kpos} < nk) else $error("word position out of range");
`endif

endmodule

// ===== design/aes_core.sv =====
// Round sequencer with the round key memory: one round per cycle.
module aes_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_key_size,
    input  logic                   i_direction,
    input  logic                   i_sched_ready,
    input  aes_pkg::t_rk_wr        i_kx_wr,
    input  logic                   i_kx_done,
    output logic                   o_kx_start,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  aes_pkg::t_blk          i_block,
    output logic                   o_res_valid,
    input  logic                   i_res_take,
    output aes_pkg::t_blk          o_result
);
    import aes_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_PRIME, S_ADD0, S_RUN, S_DONE} t_state;

    t_blk     r_mem [NUM_RK];
    t_blk     r_rd_data;
    t_state   r_state, n_state;
    t_blk     r_blk, n_blk;
    logic [3:0] r_rnd, n_rnd;
    logic [3:0] nr;
    logic [3:0] rd_k;
    t_rk_addr rd_addr;
    logic     last;

    assign nr      = nr_of(i_key_size);
    assign last    = (r_rnd == nr);
    assign rd_addr = i_direction ? (nr - rd_k) : rd_k;

    // Round key memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_kx_wr.en) r_mem[i_kx_wr.addr] <= i_kx_wr.data;
        r_rd_data <= r_mem[rd_addr];
    end

    // Next-state and datapath
    always_comb begin
        n_state    = r_state;
        n_blk      = r_blk;
        n_rnd      = r_rnd;
        rd_k       = 4'd0;
        o_kx_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_blk = i_block;
                    if (i_sched_ready) begin
                        n_state = S_ADD0;
                    end else begin
                        o_kx_start = 1'b1;
                        n_state    = S_EXPAND;
                    end
                end
            end
            S_EXPAND: begin
                if (i_kx_done) n_state = S_PRIME;
            end
            S_PRIME: begin
                n_state = S_ADD0;
            end
            S_ADD0: begin
                n_blk   = r_blk ^ r_rd_data;
                n_rnd   = 4'd1;
                rd_k    = 4'd1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (i_direction) n_blk = dec_round(r_blk, r_rd_data, last);
                else             n_blk = enc_round(r_blk, last) ^ r_rd_data;
                // last round: point the read back at the first key
                rd_k  = last ? 4'd0 : r_rnd + 4'd1;
                n_rnd = r_rnd + 4'd1;
                if (last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_blk <= n_blk;
        r_rnd <= n_rnd;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_result    = r_blk;

`ifndef SYNTHESIS
    a_prime_after_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PRIME |-> $past(r_state) == S_EXPAND) else $error("prime without expand");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (r_rnd >= 4'd1 && r_rnd <= nr)) else $error("round out of range");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kx_start |-> (r_state == S_IDLE && !i_sched_ready)) else $error("bad expand start");
    a_wr_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_kx_wr.en |-> r_state == S_EXPAND) else $error("key write outside expansion");
`endif

endmodule

// ===== design/aes_block_cipher_ecb.sv =====
// AES-128/192/256 ECB top level: configuration registers, key expander, core, output register.
// Each block is registered, gets the initial key addition, then rounds 1 to Nr (Nr = 10, 12, 14),
// one round per cycle set by the single round unit and the one-read-per-cycle round key memory.
// The first block after reset or a key/key size write first waits for expansion and a priming state.
// A new block is taken only once the core has handed its result on. Reset clears configuration,
// the schedule-valid flag and all handshake state; the round key memory is left as is.
module aes_block_cipher_ecb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aes_cfg_if.sink     i_cfg,
    aes_blk_if.sink     i_blk,
    aes_res_if.source   o_res
);
    import aes_pkg::*;

    logic [1:0]   r_key_size;
    logic         r_direction;
    logic [63:0]  r_key_w [4];
    logic         r_sched_ready;
    logic         r_out_valid;
    t_blk         r_out;

    t_rk_wr       kx_wr;
    logic         kx_done;
    logic         kx_start;
    logic         core_valid;
    logic         core_take;
    t_blk         core_result;
    logic         cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // Configuration registers and schedule-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size    <= KS_128;
            r_direction   <= 1'b0;
            r_sched_ready <= 1'b0;
            for (int k = 0; k < 4; k++) r_key_w[k] <= '0;
        end else begin
            if (kx_done) r_sched_ready <= 1'b1;
            if (cfg_we) begin
                case (i_cfg.index)
                    CFG_KEY_SIZE: begin
                        r_key_size    <= i_cfg.data[1:0];
                        r_sched_ready <= 1'b0;
                    end
                    CFG_DIRECTION: r_direction <= i_cfg.data[0];
                    CFG_KEY_W0: begin
                        r_key_w[0] <= i_cfg.data; r_sched_ready <= 1'b0;
                    end
                    CFG_KEY_W1: begin
                        r_key_w[1] <= i_cfg.data; r_sched_ready <= 1'b0;
                    end
                    CFG_KEY_W2: begin
                        r_key_w[2] <= i_cfg.data; r_sched_ready <= 1'b0;
                    end
                    CFG_KEY_W3: begin
                        r_key_w[3] <= i_cfg.data; r_sched_ready <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    aes_kexp u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (kx_start),
        .i_key_size (r_key_size),
        .i_key      ({r_key_w[0], r_key_w[1], r_key_w[2], r_key_w[3]}),
        .o_wr       (kx_wr),
        .o_done     (kx_done)
    );

    aes_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_size    (r_key_size),
        .i_direction   (r_direction),
        .i_sched_ready (r_sched_ready),
        .i_kx_wr       (kx_wr),
        .i_kx_done     (kx_done),
        .o_kx_start    (kx_start),
        .i_in_valid    (i_blk.valid),
        .o_in_ready    (i_blk.ready),
        .i_block       ({i_blk.block_high, i_blk.block_low}),
        .o_res_valid   (core_valid),
        .i_res_take    (core_take),
        .o_result      (core_result)
    );

    // Output register parts the core from the result sink
    assign core_take = core_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (core_take) r_out <= core_result;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_high = r_out[127:64];
    assign o_res.result_low  = r_out[63:0];

endmodule
